// ===== src/chat_packet_deframer_top_macros.svh =====
// Assertion macros for the chat packet deframer.
// Used by chat_packet_deframer_top; no other dependencies.
`ifndef CHAT_PACKET_DEFRAMER_TOP_MACROS_SVH
`define CHAT_PACKET_DEFRAMER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define CPD_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define CPD_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("deframer check failed");

`else

`define CPD_ASSERT_IMPL(label, clk_sig, rstn_sig, ante, cons)
`define CPD_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons)

`endif

`endif

// ===== src/cpd_pkg.sv =====
// Package for the chat packet deframer: constants, event codes and the result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpd_pkg;

    // Framing constants.
    localparam int HEADER_BYTES  = 4 + 2 + 2 + 2 + 2 + 4 + 4;
    localparam int HC_W          = $clog2(HEADER_BYTES + 1);
    localparam int KEY_MAX_CHARS = 63;
    localparam int KEY_LEN_W     = $clog2(KEY_MAX_CHARS + 1);

    localparam logic [7:0] SEP_FIRST  = 8'hC0;
    localparam logic [7:0] SEP_SECOND = 8'h80;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    // Header byte positions.
    localparam int POS_LEN_HI  = 8;
    localparam int POS_LEN_LO  = 9;
    localparam int POS_SVC_HI  = 10;
    localparam int POS_SVC_LO  = 11;
    localparam int POS_STAT_LO = 12;
    localparam int POS_STAT_HI = 15;
    localparam int POS_ID_LO   = 16;
    localparam int POS_ID_HI   = 19;

    // Result queue.
    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        EV_HEADER     = 3'd0,
        EV_KEY        = 3'd1,
        EV_VALUE      = 3'd2,
        EV_PAIR_END   = 3'd3,
        EV_PACKET_END = 3'd4
    } event_kind_t;

    typedef struct packed {
        event_kind_t  kind;
        logic [15:0]  key_number;
        logic [7:0]   value_byte;
        logic [15:0]  service_code;
        logic [31:0]  status_word;
        logic [31:0]  session_id;
        logic [15:0]  payload_length;
        logic         last_of_run;
    } result_t;

endpackage

`default_nettype wire

// ===== src/chat_packet_deframer_top.sv =====
// Chat packet deframer: header parser, key/value splitter and result queue.
// Depends on cpd_pkg and chat_packet_deframer_top_macros.svh.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+------------------------------
//  data     | in        | data_valid / data_stall | data_byte
//  event    | out       | event_valid/event_stall | event_kind .. last_of_run
//
// A byte is registered on acceptance and parsed from the input register, when it
// writes zero to three results into a four-entry result queue. A byte is parsed
// only while the queue has room for three results, so one byte per cycle is
// sustained whenever each byte yields at most one result and event_stall is low.
// A byte passes the input register and then the result queue on its way to the port.
// Reset clears the header counter, pair state and the queue; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "chat_packet_deframer_top_macros.svh"

module chat_packet_deframer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        data_valid,
    output logic             data_stall,
    input  wire logic [7:0]  data_byte,
    output logic             event_valid,
    input  wire logic        event_stall,
    output logic [2:0]       event_kind,
    output logic [15:0]      key_number,
    output logic [7:0]       value_byte,
    output logic [15:0]      service_code,
    output logic [31:0]      status_word,
    output logic [31:0]      session_id,
    output logic [15:0]      payload_length,
    output logic             last_of_run
);

    // Input register.
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       process;
    logic       accept;

    // Parser state.
    logic [cpd_pkg::HC_W-1:0]      header_count_reg, header_count_next;
    logic [15:0]                   length_reg, length_next;
    logic [15:0]                   service_reg, service_next;
    logic [31:0]                   status_reg, status_next;
    logic [31:0]                   id_reg, id_next;
    logic [15:0]                   payload_pos_reg, payload_pos_next;
    logic [7:0]                    held_byte_reg, held_byte_next;
    logic                          held_valid_reg, held_valid_next;
    logic                          in_value_reg, in_value_next;
    logic [cpd_pkg::KEY_LEN_W-1:0] key_length_reg, key_length_next;
    logic [15:0]                   key_accum_reg, key_accum_next;
    logic                          key_stopped_reg, key_stopped_next;
    logic                          pair_accepted_reg, pair_accepted_next;

    // Results of the byte being parsed.
    cpd_pkg::result_t              res [cpd_pkg::MAX_RESULTS];
    logic [cpd_pkg::RES_CNT_W-1:0] res_count;

    // Result queue.
    cpd_pkg::result_t               fifo_mem [cpd_pkg::FIFO_DEPTH];
    logic [cpd_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cpd_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                           pop;
    cpd_pkg::result_t               head;

    // Input handshake: parse when the queue can take a full run of results.
    assign process    = s1_valid_reg &&
                        (count_reg <= cpd_pkg::FIFO_CNT_W'(cpd_pkg::FIFO_DEPTH
                                                          - cpd_pkg::MAX_RESULTS));
    assign data_stall = s1_valid_reg && !process;
    assign accept     = data_valid && !data_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (process)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= data_byte;
        end
    end

    // Byte parser: next state and the results caused by the registered byte.
    always_comb
    begin
        logic [15:0] pos_inc;
        logic        last_byte;
        logic        sep;
        logic [19:0] key_mul;
        logic [7:0]  b;

        header_count_next  = header_count_reg;
        length_next        = length_reg;
        service_next       = service_reg;
        status_next        = status_reg;
        id_next            = id_reg;
        payload_pos_next   = payload_pos_reg;
        held_byte_next     = held_byte_reg;
        held_valid_next    = held_valid_reg;
        in_value_next      = in_value_reg;
        key_length_next    = key_length_reg;
        key_accum_next     = key_accum_reg;
        key_stopped_next   = key_stopped_reg;
        pair_accepted_next = pair_accepted_reg;
        res_count          = '0;
        for (int i = 0; i < cpd_pkg::MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end
        b         = s1_byte_reg;
        pos_inc   = payload_pos_reg + 16'd1;
        last_byte = 1'b0;
        sep       = 1'b0;
        key_mul   = '0;

        if (process)
        begin
            if (header_count_reg >= cpd_pkg::HC_W'(cpd_pkg::HEADER_BYTES))
            begin
                // Payload byte.
                last_byte        = (pos_inc == length_reg);
                payload_pos_next = pos_inc;
                sep = held_valid_reg && (held_byte_reg == cpd_pkg::SEP_FIRST) &&
                      (b == cpd_pkg::SEP_SECOND);
                if (sep)
                begin
                    if (!in_value_reg)
                    begin
                        pair_accepted_next = (key_length_reg != '0);
                        if (pair_accepted_next)
                        begin
                            res[res_count].kind       = cpd_pkg::EV_KEY;
                            res[res_count].key_number = key_accum_reg;
                            res_count                 = res_count + 1'b1;
                        end
                        in_value_next = 1'b1;
                    end
                    else
                    begin
                        if (pair_accepted_reg)
                        begin
                            res[res_count].kind       = cpd_pkg::EV_PAIR_END;
                            res[res_count].key_number = key_accum_reg;
                            res_count                 = res_count + 1'b1;
                        end
                        in_value_next      = 1'b0;
                        key_length_next    = '0;
                        key_accum_next     = '0;
                        key_stopped_next   = 1'b0;
                        pair_accepted_next = 1'b0;
                    end
                    held_valid_next = 1'b0;
                end
                else
                begin
                    if (held_valid_reg)
                    begin
                        if (!in_value_reg)
                        begin
                            // Key character: count it, then fold in a decimal digit.
                            if (key_length_reg <
                                cpd_pkg::KEY_LEN_W'(cpd_pkg::KEY_MAX_CHARS))
                            begin
                                key_length_next = key_length_reg + 1'b1;
                                if (!key_stopped_reg)
                                begin
                                    if ((held_byte_reg >= cpd_pkg::DIGIT_ZERO) &&
                                        (held_byte_reg <= cpd_pkg::DIGIT_NINE))
                                    begin
                                        key_mul = {1'b0, key_accum_reg, 3'b000} +
                                                  {3'b000, key_accum_reg, 1'b0} +
                                                  20'(held_byte_reg - cpd_pkg::DIGIT_ZERO);
                                        key_accum_next = (key_mul > 20'h0FFFF) ?
                                                         16'hFFFF : key_mul[15:0];
                                    end
                                    else
                                    begin
                                        key_stopped_next = 1'b1;
                                    end
                                end
                            end
                        end
                        else if (pair_accepted_reg)
                        begin
                            res[res_count].kind       = cpd_pkg::EV_VALUE;
                            res[res_count].key_number = key_accum_reg;
                            res[res_count].value_byte = held_byte_reg;
                            res_count                 = res_count + 1'b1;
                        end
                    end
                    held_byte_next  = b;
                    held_valid_next = 1'b1;
                end

                // End of payload: close any open pair, then end the packet.
                if (last_byte)
                begin
                    if (!in_value_next)
                    begin
                        if (key_length_next != '0)
                        begin
                            res[res_count].kind       = cpd_pkg::EV_KEY;
                            res[res_count].key_number = key_accum_next;
                            res_count                 = res_count + 1'b1;
                            res[res_count].kind       = cpd_pkg::EV_PAIR_END;
                            res[res_count].key_number = key_accum_next;
                            res_count                 = res_count + 1'b1;
                        end
                    end
                    else if (pair_accepted_next)
                    begin
                        res[res_count].kind       = cpd_pkg::EV_PAIR_END;
                        res[res_count].key_number = key_accum_next;
                        res_count                 = res_count + 1'b1;
                    end
                    res[res_count].kind = cpd_pkg::EV_PACKET_END;
                    res_count           = res_count + 1'b1;
                    in_value_next      = 1'b0;
                    key_length_next    = '0;
                    key_accum_next     = '0;
                    key_stopped_next   = 1'b0;
                    pair_accepted_next = 1'b0;
                    held_valid_next    = 1'b0;
                    held_byte_next     = '0;
                    header_count_next  = '0;
                end
            end
            else
            begin
                // Header byte: capture the big-endian fields.
                if (header_count_reg == cpd_pkg::HC_W'(cpd_pkg::POS_LEN_HI))
                begin
                    length_next = {b, 8'h00};
                end
                else if (header_count_reg == cpd_pkg::HC_W'(cpd_pkg::POS_LEN_LO))
                begin
                    length_next = {length_reg[15:8], b};
                end
                else if (header_count_reg == cpd_pkg::HC_W'(cpd_pkg::POS_SVC_HI))
                begin
                    service_next = {b, 8'h00};
                end
                else if (header_count_reg == cpd_pkg::HC_W'(cpd_pkg::POS_SVC_LO))
                begin
                    service_next = {service_reg[15:8], b};
                end
                else if ((header_count_reg >= cpd_pkg::HC_W'(cpd_pkg::POS_STAT_LO)) &&
                         (header_count_reg <= cpd_pkg::HC_W'(cpd_pkg::POS_STAT_HI)))
                begin
                    status_next = {status_reg[23:0], b};
                end
                else if ((header_count_reg >= cpd_pkg::HC_W'(cpd_pkg::POS_ID_LO)) &&
                         (header_count_reg <= cpd_pkg::HC_W'(cpd_pkg::POS_ID_HI)))
                begin
                    id_next = {id_reg[23:0], b};
                end

                if (header_count_reg >= cpd_pkg::HC_W'(cpd_pkg::HEADER_BYTES - 1))
                begin
                    res[res_count].kind = cpd_pkg::EV_HEADER;
                    res_count           = res_count + 1'b1;
                    payload_pos_next    = '0;
                    held_valid_next     = 1'b0;
                    held_byte_next      = '0;
                    in_value_next       = 1'b0;
                    key_length_next     = '0;
                    key_accum_next      = '0;
                    key_stopped_next    = 1'b0;
                    pair_accepted_next  = 1'b0;
                    if (length_next == 16'd0)
                    begin
                        res[res_count].kind = cpd_pkg::EV_PACKET_END;
                        res_count           = res_count + 1'b1;
                        header_count_next   = '0;
                    end
                    else
                    begin
                        header_count_next = cpd_pkg::HC_W'(cpd_pkg::HEADER_BYTES);
                    end
                end
                else
                begin
                    header_count_next = header_count_reg + 1'b1;
                end
            end
        end

        // Header fields and the end-of-run flag for every result of this byte.
        for (int i = 0; i < cpd_pkg::MAX_RESULTS; i++)
        begin
            res[i].service_code   = service_next;
            res[i].status_word    = status_next;
            res[i].session_id     = id_next;
            res[i].payload_length = length_next;
            res[i].last_of_run    = (cpd_pkg::RES_CNT_W'(i + 1) == res_count);
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg  <= '0;
            length_reg        <= '0;
            service_reg       <= '0;
            status_reg        <= '0;
            id_reg            <= '0;
            payload_pos_reg   <= '0;
            held_byte_reg     <= '0;
            held_valid_reg    <= 1'b0;
            in_value_reg      <= 1'b0;
            key_length_reg    <= '0;
            key_accum_reg     <= '0;
            key_stopped_reg   <= 1'b0;
            pair_accepted_reg <= 1'b0;
        end
        else
        begin
            header_count_reg  <= header_count_next;
            length_reg        <= length_next;
            service_reg       <= service_next;
            status_reg        <= status_next;
            id_reg            <= id_next;
            payload_pos_reg   <= payload_pos_next;
            held_byte_reg     <= held_byte_next;
            held_valid_reg    <= held_valid_next;
            in_value_reg      <= in_value_next;
            key_length_reg    <= key_length_next;
            key_accum_reg     <= key_accum_next;
            key_stopped_reg   <= key_stopped_next;
            pair_accepted_reg <= pair_accepted_next;
        end
    end

    // Result queue: up to three writes and one read a cycle.
    assign pop        = (count_reg != '0) && !event_stall;
    assign count_next = count_reg + cpd_pkg::FIFO_CNT_W'(res_count)
                        - cpd_pkg::FIFO_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < cpd_pkg::MAX_RESULTS; i++)
        begin
            if (cpd_pkg::RES_CNT_W'(i) < res_count)
            begin
                fifo_mem[wr_ptr_reg + cpd_pkg::FIFO_PTR_W'(i)] <= res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + cpd_pkg::FIFO_PTR_W'(res_count);
            rd_ptr_reg <= rd_ptr_reg + cpd_pkg::FIFO_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    // Output port.
    assign head           = fifo_mem[rd_ptr_reg];
    assign event_valid    = (count_reg != '0);
    assign event_kind     = head.kind;
    assign key_number     = head.key_number;
    assign value_byte     = head.value_byte;
    assign service_code   = head.service_code;
    assign status_word    = head.status_word;
    assign session_id     = head.session_id;
    assign payload_length = head.payload_length;
    assign last_of_run    = head.last_of_run;

    // Checks on the queue bookkeeping and parser bounds.
    `CPD_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= cpd_pkg::FIFO_CNT_W'(cpd_pkg::FIFO_DEPTH))
    `CPD_ASSERT_NEXT(a_count_track, clk, rst_n, 1'b1, count_reg == $past(count_next))
    `CPD_ASSERT_IMPL(a_idle_no_result, clk, rst_n, !process, res_count == '0)
    `CPD_ASSERT_IMPL(a_key_bound, clk, rst_n, 1'b1, key_length_reg <= cpd_pkg::KEY_LEN_W'(cpd_pkg::KEY_MAX_CHARS))

endmodule

`default_nettype wire
